/* rtl/rhsq_pkg.sv */
// Shared constants, codes and control types for the rolling hash substring query block.
// No dependencies; every other file imports this package.
package rhsq_pkg;

    localparam int unsigned HASH_W   = 30;
    localparam int unsigned MAX_LEN  = 1024;
    localparam int unsigned IDX_W    = 11;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 48;

    localparam logic [HASH_W-1:0] HASH_MOD    = 30'd1000000007;
    localparam logic [HASH_W-1:0] BASE_RESET  = 30'd31;
    localparam logic [CHAR_W-1:0] CHAR_OFFSET = 8'd96;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic rd;
        logic start_app;
        logic start_qry;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic app_ok;
        logic qry_ok;
        logic mul_done;
        logic out_free;
    } t_stat;

endpackage

/* rtl/rhsq_modmul.sv */
// Two-lane bit-serial modular multiplier: acc_k = x_k * b mod HASH_MOD, one bit of b a cycle.
// Depends on rhsq_pkg.
module rhsq_modmul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rhsq_pkg::HASH_W-1:0]   i_x0,
    input  logic [rhsq_pkg::HASH_W-1:0]   i_x1,
    input  logic [rhsq_pkg::HASH_W-1:0]   i_b,
    output logic                          o_done,
    output logic [rhsq_pkg::HASH_W-1:0]   o_acc0,
    output logic [rhsq_pkg::HASH_W-1:0]   o_acc1
);
    import rhsq_pkg::*;

    localparam int unsigned CNT_W = $clog2(HASH_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [HASH_W-1:0] r_x0, r_x1, r_b, n_b;
    logic [HASH_W-1:0] r_acc0, n_acc0, r_acc1, n_acc1;

    function automatic logic [HASH_W-1:0] step(input logic [HASH_W-1:0] acc,
                                               input logic [HASH_W-1:0] x,
                                               input logic              bit_in);
        logic [HASH_W:0] dbl;
        logic [HASH_W:0] sum;
        dbl = {acc, 1'b0};
        if (dbl >= {1'b0, HASH_MOD}) begin
            dbl = dbl - {1'b0, HASH_MOD};
        end
        sum = dbl + (bit_in ? {1'b0, x} : '0);
        if (sum >= {1'b0, HASH_MOD}) begin
            sum = sum - {1'b0, HASH_MOD};
        end
        return sum[HASH_W-1:0];
    endfunction

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_b    = r_b;
        n_acc0 = r_acc0;
        n_acc1 = r_acc1;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(HASH_W - 1);
            n_b    = i_b;
            n_acc0 = '0;
            n_acc1 = '0;
        end else if (r_busy) begin
            n_acc0 = step(r_acc0, r_x0, r_b[HASH_W-1]);
            n_acc1 = step(r_acc1, r_x1, r_b[HASH_W-1]);
            n_b    = {r_b[HASH_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x0 <= i_x0;
            r_x1 <= i_x1;
        end
        r_cnt  <= n_cnt;
        r_b    <= n_b;
        r_acc0 <= n_acc0;
        r_acc1 <= n_acc1;
    end

    assign o_done = r_done;
    assign o_acc0 = r_acc0;
    assign o_acc1 = r_acc1;

endmodule

/* rtl/rhsq_datapath.sv */
// Datapath: item registers, hash and power stores, base register, multiplier and output register.
// Depends on rhsq_pkg and rhsq_modmul.
module rhsq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rhsq_pkg::t_cmd                i_cmd,
    output rhsq_pkg::t_stat               o_stat,
    input  logic [rhsq_pkg::OP_W-1:0]     i_opcode,
    input  logic [rhsq_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [rhsq_pkg::IDX_W-1:0]    i_left_index,
    input  logic [rhsq_pkg::IDX_W-1:0]    i_right_index,
    input  logic                          i_cfg_wr_en,
    input  logic [rhsq_pkg::HASH_W-1:0]   i_cfg_wr_data,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [rhsq_pkg::HASH_W-1:0]   o_hash_value,
    output logic [rhsq_pkg::STAT_W-1:0]   o_status,
    output logic [rhsq_pkg::IDX_W-1:0]    o_string_length
);
    import rhsq_pkg::*;

    logic [HASH_W-1:0] mem_h [0:MAX_LEN];
    logic [HASH_W-1:0] mem_p [0:MAX_LEN];

    logic [HASH_W-1:0] r_base;
    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_left, r_right;
    logic [IDX_W-1:0]  r_len, n_len;
    logic [HASH_W-1:0] r_hlast, n_hlast, r_plast, n_plast;
    logic [HASH_W-1:0] r_rd_hl, r_rd_hr, r_rd_p;
    logic              r_l_zero, r_r_zero, r_d_zero;
    logic              r_o_valid;
    logic [HASH_W-1:0] r_o_hash, n_o_hash;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [IDX_W-1:0]  r_o_len, n_o_len;

    logic [IDX_W-1:0]  span;
    logic [IDX_W-1:0]  wr_addr;
    logic              app_ok, qry_ok, mem_wr;
    logic              mul_start, mul_done;
    logic [HASH_W-1:0] mul_x0, mul_x1, mul_b, acc0, acc1;
    logic [HASH_W-1:0] hl, hr, pd, char_map, h_app, h_qry;
    logic [HASH_W:0]   app_sum;

    assign span    = r_right - r_left;
    assign wr_addr = r_len + 1'b1;
    assign app_ok  = (r_op == OP_APPEND) && (r_len < IDX_W'(MAX_LEN));
    assign qry_ok  = (r_op == OP_QUERY) && (r_left <= r_right) && (r_right <= r_len);

    assign hl = r_l_zero ? '0 : r_rd_hl;
    assign hr = r_r_zero ? '0 : r_rd_hr;
    assign pd = r_d_zero ? HASH_W'(1) : r_rd_p;

    assign mul_start = i_cmd.start_app || i_cmd.start_qry;
    assign mul_x0    = i_cmd.start_app ? r_hlast : hl;
    assign mul_x1    = i_cmd.start_app ? r_plast : '0;
    assign mul_b     = i_cmd.start_app ? r_base  : pd;

    rhsq_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x0    (mul_x0),
        .i_x1    (mul_x1),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_acc0  (acc0),
        .o_acc1  (acc1)
    );

    always_comb begin
        if (r_char >= CHAR_OFFSET) begin
            char_map = HASH_W'(r_char - CHAR_OFFSET);
        end else begin
            char_map = HASH_MOD - HASH_W'(CHAR_OFFSET - r_char);
        end
        app_sum = {1'b0, acc0} + {1'b0, char_map};
        if (app_sum >= {1'b0, HASH_MOD}) begin
            app_sum = app_sum - {1'b0, HASH_MOD};
        end
        h_app = app_sum[HASH_W-1:0];
        if (hr >= acc0) begin
            h_qry = hr - acc0;
        end else begin
            h_qry = hr + (HASH_MOD - acc0);
        end
    end

    always_comb begin
        n_len      = r_len;
        n_hlast    = r_hlast;
        n_plast    = r_plast;
        n_o_hash   = '0;
        n_o_status = ST_OK;
        n_o_len    = r_len;
        mem_wr     = 1'b0;
        unique case (r_op)
            OP_APPEND: begin
                if (app_ok) begin
                    n_o_hash = h_app;
                    n_o_len  = wr_addr;
                    n_len    = wr_addr;
                    n_hlast  = h_app;
                    n_plast  = acc1;
                    mem_wr   = i_cmd.finish;
                end else begin
                    n_o_status = ST_FULL;
                end
            end
            OP_QUERY: begin
                if (qry_ok) begin
                    n_o_hash = h_qry;
                end else begin
                    n_o_status = ST_BAD_RANGE;
                end
            end
            OP_CLEAR: begin
                n_o_len = '0;
                n_len   = '0;
                n_hlast = '0;
                n_plast = HASH_W'(1);
            end
            OP_NOP: begin
                n_o_len = r_len;
            end
            default: begin
                n_o_len = r_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= BASE_RESET;
            r_len     <= '0;
            r_hlast   <= '0;
            r_plast   <= HASH_W'(1);
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (i_cmd.finish) begin
                r_len     <= n_len;
                r_hlast   <= n_hlast;
                r_plast   <= n_plast;
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_char  <= i_char_code;
            r_left  <= i_left_index;
            r_right <= i_right_index;
        end
        if (i_cmd.finish) begin
            r_o_hash   <= n_o_hash;
            r_o_status <= n_o_status;
            r_o_len    <= n_o_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem_h[wr_addr] <= h_app;
            mem_p[wr_addr] <= acc1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_hl  <= mem_h[r_left];
            r_rd_hr  <= mem_h[r_right];
            r_rd_p   <= mem_p[span];
            r_l_zero <= (r_left == '0);
            r_r_zero <= (r_right == '0);
            r_d_zero <= (span == '0);
        end
    end

    assign o_stat.app_ok   = app_ok;
    assign o_stat.qry_ok   = qry_ok;
    assign o_stat.mul_done = mul_done;
    assign o_stat.out_free = !r_o_valid || i_m_tready;

    assign o_m_tvalid      = r_o_valid;
    assign o_hash_value    = r_o_hash;
    assign o_status        = r_o_status;
    assign o_string_length = r_o_len;

endmodule

/* rtl/rhsq_ctrl.sv */
// Controller state machine: sequences accept, store read, multiply and result write-back.
// Depends on rhsq_pkg.
module rhsq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  rhsq_pkg::t_stat   i_stat,
    output rhsq_pkg::t_cmd    o_cmd
);
    import rhsq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_tready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.rd = 1'b1;
                priority if (i_stat.app_ok) begin
                    o_cmd.start_app = 1'b1;
                    n_state         = S_MUL;
                end else if (i_stat.qry_ok) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_WB;
                end
            end
            S_RD: begin
                o_cmd.start_qry = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                if (i_stat.mul_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/rolling_hash_substring_query.sv */
// Polynomial rolling hash store with substring queries, mod 1000000007.
// Append: accept, decode, multiply, write-back; query adds a store read before the multiply;
// clear and others skip both. Serial multiplier: one base bit a cycle; one item at a time.
// The output register lets a new item be accepted while a result waits.
// Synchronous active-low reset: length 0, base 31, no result pending; no clearing pass.
module rolling_hash_substring_query (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [rhsq_pkg::HASH_W-1:0]     i_cfg_wr_data,  // hash_base
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rhsq_pkg::S_DATA_W-1:0]   i_s_tdata,  // char_code, left_index, right_index, pad
    input  logic [rhsq_pkg::OP_W-1:0]       i_s_tuser,  // opcode
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rhsq_pkg::M_DATA_W-1:0]   o_m_tdata,  // hash_value, string_length, pad
    output logic [rhsq_pkg::STAT_W-1:0]     o_m_tuser   // status
);
    import rhsq_pkg::*;

    localparam int unsigned L_LO = CHAR_W;
    localparam int unsigned R_LO = CHAR_W + IDX_W;
    localparam int unsigned S_USED = R_LO + IDX_W;
    localparam int unsigned M_USED = HASH_W + IDX_W;

    t_cmd              cmd;
    t_stat             stat;
    logic [HASH_W-1:0] hash_value;
    logic [IDX_W-1:0]  string_length;

    rhsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rhsq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_s_tuser),
        .i_char_code     (i_s_tdata[CHAR_W-1:0]),
        .i_left_index    (i_s_tdata[R_LO-1:L_LO]),
        .i_right_index   (i_s_tdata[S_USED-1:R_LO]),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_hash_value    (hash_value),
        .o_status        (o_m_tuser),
        .o_string_length (string_length)
    );

    assign o_m_tdata = {{(M_DATA_W - M_USED){1'b0}}, string_length, hash_value};

endmodule
